FILE: rtl/bce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

    // Number format: signed two's complement, Q12.20
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 20;
    localparam int LIMIT_BITS = WORD_BITS - 1;
    localparam int ACC_BITS   = WORD_BITS + 2;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;

    localparam int COUNT_BITS     = 8;
    localparam int CLASS_BITS     = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS  = 16;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [ACC_BITS-1:0]   acc_t;
    typedef logic [PROD_BITS-1:0]  prod_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CLASS_BITS-1:0] class_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONST_REAL      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONST_IMAG      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ESCAPE_LIMIT    = 2'd3;

    // Region classes
    localparam class_t CLASS_NONE     = 2'd0;
    localparam class_t CLASS_BOTH_IN  = 2'd1;
    localparam class_t CLASS_REAL_OUT = 2'd2;
    localparam class_t CLASS_IMAG_OUT = 2'd3;

    // Signed part strictly below the non-negative escape limit
    function automatic logic below_limit(word_t x, limit_t e);
        return x[WORD_BITS-1] | (x[LIMIT_BITS-1:0] < e);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/biomorph_cubic_escape_iterator.sv
`timescale 1ns / 1ps
`default_nettype none
// A point is accepted in the idle state; each pass then runs the check, multiply and
// update states, and the result is registered once the escape or iteration test ends it.
// One point at a time: a new point is taken only in the idle state. A pass is six
// products through one 32x32 multiplier, each registered before its scaling stage, then an update.
// Reset (rst_n low, asynchronous) clears control, the iterate state and loads the
// default constant, iteration limit and escape limit.
module biomorph_cubic_escape_iterator
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [bce_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [bce_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    // Input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [2*bce_pkg::WORD_BITS-1:0]        s_tdata,  // start_real, start_imag
    // Output stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [bce_pkg::OUT_DATA_BITS-1:0]           m_tdata   // iteration_count, region_class, zero pad
);
    import bce_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [2:0] SEQ_LAST = 3'd6;

    // Control and configuration
    logic [2:0] state_reg, state_next;
    logic [2:0] seq_reg, seq_next;
    word_t      const_real_reg, const_real_next;
    word_t      const_imag_reg, const_imag_next;
    count_t     iter_limit_reg, iter_limit_next;
    limit_t     escape_limit_reg, escape_limit_next;
    count_t     step_count_reg, step_count_next;
    class_t     class_reg, class_next;
    logic       out_valid_reg, out_valid_next;
    count_t     out_count_reg, out_count_next;
    class_t     out_class_reg, out_class_next;

    // Iterate state
    word_t cur_real_reg, cur_real_next;
    word_t cur_imag_reg, cur_imag_next;
    word_t prev_real_reg, prev_real_next;
    word_t prev_imag_reg, prev_imag_next;

    // Operand magnitudes and signs for the multiplier
    word_t re_mag_reg, re_mag_next;
    word_t im_mag_reg, im_mag_next;
    logic  re_sign_reg, re_sign_next;
    logic  im_sign_reg, im_sign_next;

    // Shared multiplier datapath
    prod_t prod_reg, prod_next;
    logic  neg_reg, neg_next;
    word_t re2_reg, re2_next;
    word_t im2_reg, im2_next;
    word_t re2x3_reg, re2x3_next;
    word_t im2x3_reg, im2x3_next;
    acc_t  acc_real_reg, acc_real_next;
    acc_t  acc_imag_reg, acc_imag_next;

    word_t op_a;
    word_t op_b;
    logic  op_neg;

    logic [SHIFT_BITS-1:0] shifted;
    logic [SHIFT_BITS-1:0] sat_lim;
    logic [SHIFT_BITS-1:0] clamped;
    word_t                 clamped_w;
    word_t                 scaled;
    logic [WORD_BITS+1:0]  triple_sum;
    word_t                 triple;
    acc_t                  scaled_ext;
    acc_t                  const_real_ext;
    acc_t                  const_imag_ext;

    acc_t  abs_real;
    acc_t  abs_imag;
    word_t new_real;
    word_t new_imag;

    word_t start_real;
    word_t start_imag;
    logic  real_in;
    logic  imag_in;
    logic  keep_going;

    assign start_real = s_tdata[WORD_BITS-1:0];
    assign start_imag = s_tdata[2*WORD_BITS-1:WORD_BITS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_BITS-COUNT_BITS-CLASS_BITS){1'b0}}, out_class_reg,
                        out_count_reg};

    // Select multiplier operands for the product issued this cycle
    always_comb
    begin
        op_a   = re_mag_reg;
        op_b   = re_mag_reg;
        op_neg = 1'b0;
        unique case (seq_reg)
            3'd0:
            begin
                op_a   = re_mag_reg;
                op_b   = re_mag_reg;
                op_neg = 1'b0;
            end
            3'd1:
            begin
                op_a   = im_mag_reg;
                op_b   = im_mag_reg;
                op_neg = 1'b0;
            end
            3'd2:
            begin
                op_a   = re2_reg;
                op_b   = re_mag_reg;
                op_neg = re_sign_reg;
            end
            3'd3:
            begin
                op_a   = im2x3_reg;
                op_b   = re_mag_reg;
                op_neg = re_sign_reg;
            end
            3'd4:
            begin
                op_a   = re2x3_reg;
                op_b   = im_mag_reg;
                op_neg = im_sign_reg;
            end
            3'd5:
            begin
                op_a   = im2_reg;
                op_b   = im_mag_reg;
                op_neg = im_sign_reg;
            end
            default:
            begin
                op_a   = re_mag_reg;
                op_b   = re_mag_reg;
                op_neg = 1'b0;
            end
        endcase
    end

    // Scale the registered product, truncate toward zero and saturate
    always_comb
    begin
        shifted    = prod_reg[PROD_BITS-1:FRAC_BITS];
        sat_lim    = neg_reg ? (SHIFT_BITS'(WORD_MAX) + 1'b1) : SHIFT_BITS'(WORD_MAX);
        clamped    = (shifted > sat_lim) ? sat_lim : shifted;
        clamped_w  = clamped[WORD_BITS-1:0];
        scaled     = neg_reg ? (~clamped_w + 1'b1) : clamped_w;
        triple_sum = {2'b00, scaled} + {1'b0, scaled, 1'b0};
        triple     = (triple_sum > {2'b00, WORD_MAX}) ? WORD_MAX : triple_sum[WORD_BITS-1:0];
        scaled_ext     = {{(ACC_BITS-WORD_BITS){scaled[WORD_BITS-1]}}, scaled};
        const_real_ext = {{(ACC_BITS-WORD_BITS){const_real_reg[WORD_BITS-1]}}, const_real_reg};
        const_imag_ext = {{(ACC_BITS-WORD_BITS){const_imag_reg[WORD_BITS-1]}}, const_imag_reg};
    end

    // Saturate the sums and fold to absolute value
    always_comb
    begin
        abs_real = acc_real_reg[ACC_BITS-1] ? (~acc_real_reg + 1'b1) : acc_real_reg;
        abs_imag = acc_imag_reg[ACC_BITS-1] ? (~acc_imag_reg + 1'b1) : acc_imag_reg;
        new_real = (abs_real > {2'b00, WORD_MAX}) ? WORD_MAX : abs_real[WORD_BITS-1:0];
        new_imag = (abs_imag > {2'b00, WORD_MAX}) ? WORD_MAX : abs_imag[WORD_BITS-1:0];
    end

    // Escape tests on the registered iterate
    always_comb
    begin
        real_in    = below_limit(cur_real_reg, escape_limit_reg);
        imag_in    = below_limit(cur_imag_reg, escape_limit_reg);
        keep_going = (step_count_reg < iter_limit_reg) &&
                     (real_in || imag_in ||
                      below_limit(prev_real_reg, escape_limit_reg) ||
                      below_limit(prev_imag_reg, escape_limit_reg));
    end

    // Sequencer and register next values
    always_comb
    begin
        state_next        = state_reg;
        seq_next          = seq_reg;
        const_real_next   = const_real_reg;
        const_imag_next   = const_imag_reg;
        iter_limit_next   = iter_limit_reg;
        escape_limit_next = escape_limit_reg;
        step_count_next   = step_count_reg;
        class_next        = class_reg;
        out_valid_next    = out_valid_reg;
        out_count_next    = out_count_reg;
        out_class_next    = out_class_reg;
        cur_real_next     = cur_real_reg;
        cur_imag_next     = cur_imag_reg;
        prev_real_next    = prev_real_reg;
        prev_imag_next    = prev_imag_reg;
        re_mag_next       = re_mag_reg;
        im_mag_next       = im_mag_reg;
        re_sign_next      = re_sign_reg;
        im_sign_next      = im_sign_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        re2_next          = re2_reg;
        im2_next          = im2_reg;
        re2x3_next        = re2x3_reg;
        im2x3_next        = im2x3_reg;
        acc_real_next     = acc_real_reg;
        acc_imag_next     = acc_imag_reg;

        // Drop the result once the downstream side takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Apply configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CONST_REAL:      const_real_next   = cfg_data[WORD_BITS-1:0];
                REG_CONST_IMAG:      const_imag_next   = cfg_data[WORD_BITS-1:0];
                REG_ITERATION_LIMIT: iter_limit_next   = cfg_data[COUNT_BITS-1:0];
                REG_ESCAPE_LIMIT:    escape_limit_next = cfg_data[LIMIT_BITS-1:0];
                default:             ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Load the starting point of a new request
                if (s_tvalid)
                begin
                    cur_real_next   = start_real;
                    cur_imag_next   = start_imag;
                    re_sign_next    = start_real[WORD_BITS-1];
                    im_sign_next    = start_imag[WORD_BITS-1];
                    re_mag_next     = start_real[WORD_BITS-1] ? (~start_real + 1'b1) : start_real;
                    im_mag_next     = start_imag[WORD_BITS-1] ? (~start_imag + 1'b1) : start_imag;
                    step_count_next = '0;
                    class_next      = CLASS_NONE;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Classify the last pass, then decide on another one
                if (step_count_reg != '0)
                begin
                    priority if (real_in && imag_in)
                        class_next = CLASS_BOTH_IN;
                    else if (imag_in)
                        class_next = CLASS_REAL_OUT;
                    else if (real_in)
                        class_next = CLASS_IMAG_OUT;
                    else
                        // both parts out: hold the earlier class
                        class_next = class_reg;
                end
                if (keep_going)
                begin
                    seq_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                // Issue a product and post-process the one held in the product register
                if (seq_reg != SEQ_LAST)
                begin
                    prod_next = PROD_BITS'(op_a) * PROD_BITS'(op_b);
                    neg_next  = op_neg;
                end
                unique case (seq_reg)
                    3'd1:
                    begin
                        re2_next   = scaled;
                        re2x3_next = triple;
                    end
                    3'd2:
                    begin
                        im2_next   = scaled;
                        im2x3_next = triple;
                    end
                    3'd3: acc_real_next = scaled_ext + const_real_ext;
                    3'd4: acc_real_next = acc_real_reg - scaled_ext;
                    3'd5: acc_imag_next = scaled_ext + const_imag_ext;
                    3'd6: acc_imag_next = acc_imag_reg - scaled_ext;
                    default: ;
                endcase
                if (seq_reg == SEQ_LAST)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    seq_next = seq_reg + 3'd1;
                end
            end
            ST_FINAL:
            begin
                // Advance the iterate by one pass
                prev_real_next  = cur_real_reg;
                prev_imag_next  = cur_imag_reg;
                cur_real_next   = new_real;
                cur_imag_next   = new_imag;
                re_mag_next     = new_real;
                im_mag_next     = new_imag;
                re_sign_next    = 1'b0;
                im_sign_next    = 1'b0;
                step_count_next = step_count_reg + 1'b1;
                state_next      = ST_CHECK;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = step_count_reg;
                    out_class_next = class_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and iterate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seq_reg          <= '0;
            const_real_reg   <= word_t'(32'sd1121976);
            const_imag_reg   <= word_t'(32'sd105);
            iter_limit_reg   <= count_t'(8'd150);
            escape_limit_reg <= limit_t'(31'd83886080);
            step_count_reg   <= '0;
            class_reg        <= CLASS_NONE;
            out_valid_reg    <= 1'b0;
            cur_real_reg     <= '0;
            cur_imag_reg     <= '0;
            prev_real_reg    <= '0;
            prev_imag_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            seq_reg          <= seq_next;
            const_real_reg   <= const_real_next;
            const_imag_reg   <= const_imag_next;
            iter_limit_reg   <= iter_limit_next;
            escape_limit_reg <= escape_limit_next;
            step_count_reg   <= step_count_next;
            class_reg        <= class_next;
            out_valid_reg    <= out_valid_next;
            cur_real_reg     <= cur_real_next;
            cur_imag_reg     <= cur_imag_next;
            prev_real_reg    <= prev_real_next;
            prev_imag_reg    <= prev_imag_next;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
        out_class_reg <= out_class_next;
        re_mag_reg    <= re_mag_next;
        im_mag_reg    <= im_mag_next;
        re_sign_reg   <= re_sign_next;
        im_sign_reg   <= im_sign_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        re2_reg       <= re2_next;
        im2_reg       <= im2_next;
        re2x3_reg     <= re2x3_next;
        im2x3_reg     <= im2x3_next;
        acc_real_reg  <= acc_real_next;
        acc_imag_reg  <= acc_imag_next;
    end

endmodule

`default_nettype wire
